### sv/jsu_pkg.sv
// jsu_pkg: types, status codes and character constants for the JSON string unescape unit.
// Depends on nothing; used by jsu_decode and json_string_unescape_unit.
`default_nettype none
package jsu_pkg;

	typedef enum logic [1:0] {
		MODE_WAIT = 2'd0,
		MODE_TEXT = 2'd1,
		MODE_ESC  = 2'd2,
		MODE_HEX  = 2'd3
	} mode_t;

	localparam logic [2:0] ST_BYTE    = 3'd0;
	localparam logic [2:0] ST_END     = 3'd1;
	localparam logic [2:0] ST_NO_OPEN = 3'd2;
	localparam logic [2:0] ST_BAD_ESC = 3'd3;
	localparam logic [2:0] ST_BAD_HEX = 3'd4;
	localparam logic [2:0] ST_WIDE    = 3'd5;
	localparam logic [2:0] ST_NEWLINE = 3'd6;
	localparam logic [2:0] ST_EOT     = 3'd7;

	localparam logic [7:0] CH_NUL       = 8'h00;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH     = 8'h2F;
	localparam logic [7:0] CH_LF        = 8'h0A;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_BS        = 8'h08;
	localparam logic [7:0] CH_FF        = 8'h0C;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_LOW_B     = 8'h62;
	localparam logic [7:0] CH_LOW_F     = 8'h66;
	localparam logic [7:0] CH_LOW_N     = 8'h6E;
	localparam logic [7:0] CH_LOW_R     = 8'h72;
	localparam logic [7:0] CH_LOW_T     = 8'h74;
	localparam logic [7:0] CH_LOW_U     = 8'h75;
	localparam logic [7:0] CH_DIGIT_0   = 8'h30;
	localparam logic [7:0] CH_DIGIT_9   = 8'h39;
	localparam logic [7:0] CH_LOW_A     = 8'h61;
	localparam logic [7:0] CH_UP_A      = 8'h41;
	localparam logic [7:0] CH_UP_F      = 8'h46;

	localparam logic [1:0] HEX_LAST = 2'd3;

	typedef struct packed {
		mode_t      mode;
		logic [1:0] hex_cnt;
		logic [7:0] code_lo;
		logic       wide;
	} state_t;

	typedef struct packed {
		logic       has;
		logic [7:0] out_byte;
		logic [2:0] status;
		logic       last;
	} result_t;

	localparam state_t STATE_RESET = '{mode: MODE_WAIT, hex_cnt: 2'd0, code_lo: 8'd0, wide: 1'b0};

	// Returns {is_hex, value}.
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [7:0] d;
		begin
			d = 8'd0;
			if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
				d = c - CH_DIGIT_0;
				hex_digit = {1'b1, d[3:0]};
			end else if (c >= CH_LOW_A && c <= CH_LOW_F) begin
				d = c - CH_LOW_A + 8'd10;
				hex_digit = {1'b1, d[3:0]};
			end else if (c >= CH_UP_A && c <= CH_UP_F) begin
				d = c - CH_UP_A + 8'd10;
				hex_digit = {1'b1, d[3:0]};
			end else begin
				hex_digit = {1'b0, d[3:0]};
			end
		end
	endfunction

endpackage
`default_nettype wire

### sv/jsu_decode.sv
// jsu_decode: next-state and result logic for one text byte of a JSON string literal.
// Depends on jsu_pkg (state_t, result_t, mode and status codes, hex_digit).
`default_nettype none
module jsu_decode (
	input  wire logic [7:0]      char_in,
	input  wire jsu_pkg::state_t cur,
	output jsu_pkg::state_t      nxt,
	output jsu_pkg::result_t     res
);

	logic [4:0] hd;
	logic [7:0] shifted;
	logic       wide_next;

	assign hd        = jsu_pkg::hex_digit(char_in);
	assign shifted   = {cur.code_lo[3:0], hd[3:0]};
	assign wide_next = cur.wide | (cur.code_lo[7:4] != 4'd0);

	always_comb begin
		nxt          = cur;
		res.has      = 1'b0;
		res.out_byte = 8'd0;
		res.status   = jsu_pkg::ST_BYTE;
		res.last     = 1'b0;
		if (char_in == jsu_pkg::CH_NUL) begin
			res.has    = 1'b1;
			res.status = jsu_pkg::ST_EOT;
		end else begin
			unique case (cur.mode)
				jsu_pkg::MODE_WAIT: begin
					if (char_in == jsu_pkg::CH_QUOTE) begin
						nxt.mode = jsu_pkg::MODE_TEXT;
					end else begin
						res.has    = 1'b1;
						res.status = jsu_pkg::ST_NO_OPEN;
					end
				end
				jsu_pkg::MODE_TEXT: begin
					if (char_in == jsu_pkg::CH_BACKSLASH) begin
						nxt.mode = jsu_pkg::MODE_ESC;
					end else if (char_in == jsu_pkg::CH_QUOTE) begin
						res.has    = 1'b1;
						res.status = jsu_pkg::ST_END;
					end else if (char_in == jsu_pkg::CH_LF || char_in == jsu_pkg::CH_CR) begin
						res.has    = 1'b1;
						res.status = jsu_pkg::ST_NEWLINE;
					end else begin
						res.has      = 1'b1;
						res.out_byte = char_in;
					end
				end
				jsu_pkg::MODE_ESC: begin
					nxt.mode = jsu_pkg::MODE_TEXT;
					res.has  = 1'b1;
					case (char_in)
						jsu_pkg::CH_BACKSLASH: res.out_byte = jsu_pkg::CH_BACKSLASH;
						jsu_pkg::CH_SLASH:     res.out_byte = jsu_pkg::CH_SLASH;
						jsu_pkg::CH_QUOTE:     res.out_byte = jsu_pkg::CH_QUOTE;
						jsu_pkg::CH_LOW_B:     res.out_byte = jsu_pkg::CH_BS;
						jsu_pkg::CH_LOW_F:     res.out_byte = jsu_pkg::CH_FF;
						jsu_pkg::CH_LOW_N:     res.out_byte = jsu_pkg::CH_LF;
						jsu_pkg::CH_LOW_R:     res.out_byte = jsu_pkg::CH_CR;
						jsu_pkg::CH_LOW_T:     res.out_byte = jsu_pkg::CH_TAB;
						jsu_pkg::CH_LOW_U: begin
							res.has     = 1'b0;
							nxt.mode    = jsu_pkg::MODE_HEX;
							nxt.hex_cnt = 2'd0;
							nxt.code_lo = 8'd0;
							nxt.wide    = 1'b0;
						end
						default: res.status = jsu_pkg::ST_BAD_ESC;
					endcase
				end
				jsu_pkg::MODE_HEX: begin
					if (!hd[4]) begin
						res.has    = 1'b1;
						res.status = jsu_pkg::ST_BAD_HEX;
					end else if (cur.hex_cnt != jsu_pkg::HEX_LAST) begin
						nxt.hex_cnt = cur.hex_cnt + 2'd1;
						nxt.code_lo = shifted;
						nxt.wide    = wide_next;
					end else if (wide_next) begin
						res.has    = 1'b1;
						res.status = jsu_pkg::ST_WIDE;
					end else begin
						res.has      = 1'b1;
						res.out_byte = shifted;
						nxt          = jsu_pkg::STATE_RESET;
						nxt.mode     = jsu_pkg::MODE_TEXT;
					end
				end
				default: nxt = jsu_pkg::STATE_RESET;
			endcase
		end
		if (res.has && res.status != jsu_pkg::ST_BYTE) begin
			res.last = 1'b1;
			nxt      = jsu_pkg::STATE_RESET;
		end
	end

endmodule
`default_nettype wire

### sv/json_string_unescape_unit.sv
// json_string_unescape_unit: top level of the JSON string literal decoder.
// Depends on jsu_pkg and jsu_decode.
//
// Usage:
//   Input channel (in_valid/in_ready, char_in) takes one text byte per request;
//   a zero byte marks end of text. Output channel (out_valid/out_ready, out_byte,
//   status, last) gives zero or one result per input byte: a decoded byte with
//   status 0, or a closing status 1..7 with last set and out_byte zero.
//   Quote, backslash, u and hex-digit bytes that only advance decoding give no result.
// Timing:
//   An accepted byte sits in the input register; its result is then loaded
//   into the output register and shown from then on.
//   One byte per cycle is sustained while the output is not stalled: the decoder is a single combinational step
//   between the input register and the output register.
// Stall and reset:
//   While the receiver holds out_ready low with a result pending, a byte in the input
//   register that needs the output is held there and in_ready drops; other bytes advance.
//   Reset clears both valid flags and puts the decoder in its wait-for-quote state.
`default_nettype none
module json_string_unescape_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] char_in,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic [2:0]      status,
	output logic            last
);

	logic             valid_s1;
	logic [7:0]       char_s1;
	jsu_pkg::state_t  state_q;
	jsu_pkg::state_t  state_nxt;
	jsu_pkg::result_t res;
	logic             out_free;
	logic             advance;

	jsu_decode u_decode (
		.char_in (char_s1),
		.cur     (state_q),
		.nxt     (state_nxt),
		.res     (res)
	);

	assign out_free = !out_valid || out_ready;
	assign advance  = valid_s1 && (!res.has || out_free);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			state_q   <= jsu_pkg::STATE_RESET;
			out_valid <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				state_q <= state_nxt;
			end
			if (out_free) begin
				out_valid <= advance && res.has;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_in;
		end
		if (out_free && advance && res.has) begin
			out_byte <= res.out_byte;
			status   <= res.status;
			last     <= res.last;
		end
	end

	a_last_is_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (status != jsu_pkg::ST_BYTE)))
		else $error("last does not match status");

	a_error_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != jsu_pkg::ST_BYTE) |-> (out_byte == 8'd0))
		else $error("out_byte nonzero on a closing status");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(char_s1)))
		else $error("stalled input byte lost or changed");

	a_hex_cnt_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.hex_cnt != 2'd0) |-> (state_q.mode == jsu_pkg::MODE_HEX))
		else $error("hex digit count set outside a unicode escape");

	a_code_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.mode != jsu_pkg::MODE_HEX) |-> (state_q.code_lo == 8'd0 && !state_q.wide))
		else $error("code point left over outside a unicode escape");

endmodule
`default_nettype wire
